FILE: rtl/core/snd_pkg.sv
// Shared width, stage record and step function for the signed divider pipeline.
package snd_pkg;

   localparam int WIDTH = 32;
   localparam int DATA_BITS = 2 * WIDTH;
   localparam int FLAG_BITS = 2;

   // Record carried by the step and correction stages.
   typedef struct packed {
      logic                    valid;
      logic signed [WIDTH:0]   rem;     // partial remainder, one bit wider than operands
      logic [WIDTH-1:0]        acc;     // dividend bits shifting out, quotient bits in
      logic [WIDTH-1:0]        dvs;     // divisor magnitude
      logic                    neg_q;
      logic                    neg_r;
      logic                    zero;
      logic                    ovf;
   } stage_type;

   // One non-restoring step: shift in the next dividend bit, then add or
   // subtract the divisor according to the sign of the partial remainder.
   function automatic stage_type div_step(input stage_type cur);
      stage_type             nxt;
      logic signed [WIDTH+1:0] shifted;
      logic signed [WIDTH+1:0] dvs_ext;
      logic signed [WIDTH+1:0] sum;
      nxt     = cur;
      shifted = {cur.rem, cur.acc[WIDTH-1]};
      dvs_ext = $signed({2'b00, cur.dvs});
      if (cur.rem[WIDTH]) begin
         sum = shifted + dvs_ext;
      end else begin
         sum = shifted - dvs_ext;
      end
      nxt.rem = sum[WIDTH:0];
      nxt.acc = {cur.acc[WIDTH-2:0], ~sum[WIDTH]};
      return nxt;
   endfunction

endpackage

FILE: rtl/core/signed_nonrestoring_divider_unit.sv
// Pipelined signed non-restoring divider, top level.
// One division enters per clock unless the pipeline holds, and results leave in order.
// The first stage forms the operand magnitudes, one register stage per quotient bit runs
// the non-restoring add/subtract of WIDTH+2 bits, one stage corrects a negative final
// remainder and one applies the signs. The quotient truncates toward zero and the
// remainder takes the dividend's sign. A zero divisor gives an all-ones quotient, the
// dividend as remainder and zero_divisor set; the most negative value divided by minus
// one wraps to the most negative value with overflowed set. While a result waits on
// rsp_tready the whole pipeline holds and req_tready is low.
module signed_nonrestoring_divider_unit
   import snd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,   // dividend, divisor
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,   // quotient, remainder
   output logic [FLAG_BITS-1:0] rsp_tuser    // zero_divisor, overflowed
);

   stage_type               step_ff [0:WIDTH];
   stage_type               step_in [0:WIDTH];
   stage_type               corr_ff;
   stage_type               corr_in;
   logic                    out_valid_ff;
   logic [WIDTH-1:0]        quo_ff;
   logic [WIDTH-1:0]        rem_ff;
   logic                    zero_ff;
   logic                    ovf_ff;
   logic [WIDTH-1:0]        quo_in;
   logic [WIDTH-1:0]        rem_in;
   logic                    advance;

   logic signed [WIDTH-1:0] dividend;
   logic signed [WIDTH-1:0] divisor;
   logic [WIDTH-1:0]        dvd_mag;
   logic [WIDTH-1:0]        dvs_mag;
   logic signed [WIDTH:0]   rem_fix;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign dividend = req_tdata[WIDTH-1:0];
   assign divisor  = req_tdata[DATA_BITS-1:WIDTH];

   // Operand preparation and the add/subtract steps
   always_comb begin
      dvd_mag = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
      dvs_mag = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
      step_in[0].valid = req_tvalid;
      step_in[0].rem   = '0;
      step_in[0].acc   = dvd_mag;
      step_in[0].dvs   = dvs_mag;
      step_in[0].zero  = (divisor == '0);
      // zero divisor: quotient stays all ones, remainder rebuilds the dividend
      step_in[0].neg_q = (dividend[WIDTH-1] ^ divisor[WIDTH-1]) && (divisor != '0);
      step_in[0].neg_r = dividend[WIDTH-1];
      step_in[0].ovf   = (dividend == {1'b1, {(WIDTH-1){1'b0}}}) && (divisor == '1);
      for (int k = 1; k <= WIDTH; k++) begin
         step_in[k] = div_step(step_ff[k-1]);
      end
   end

   // Remainder correction
   always_comb begin
      corr_in = step_ff[WIDTH];
      rem_fix = step_ff[WIDTH].rem + $signed({1'b0, step_ff[WIDTH].dvs});
      if (step_ff[WIDTH].rem[WIDTH]) begin
         corr_in.rem = rem_fix;
      end
   end

   // Sign fix
   always_comb begin
      quo_in = corr_ff.neg_q ? (~corr_ff.acc + 1'b1) : corr_ff.acc;
      rem_in = corr_ff.neg_r ? (~corr_ff.rem[WIDTH-1:0] + 1'b1) : corr_ff.rem[WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= WIDTH; k++) begin
            step_ff[k].valid <= 1'b0;
         end
         corr_ff.valid <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         for (int k = 0; k <= WIDTH; k++) begin
            step_ff[k] <= step_in[k];
         end
         corr_ff      <= corr_in;
         out_valid_ff <= corr_ff.valid;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         zero_ff      <= corr_ff.zero;
         ovf_ff       <= corr_ff.ovf;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rem_ff, quo_ff};
   assign rsp_tuser  = {ovf_ff, zero_ff};

   a_zero_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[WIDTH-1:0] == '1))
      else $error("zero divisor without all-ones quotient");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("zero_divisor and overflowed both set");

   a_ovf_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         ((rsp_tdata[WIDTH-1:0] == {1'b1, {(WIDTH-1){1'b0}}})
          && (rsp_tdata[DATA_BITS-1:WIDTH] == '0)))
      else $error("overflow result not most-negative quotient with zero remainder");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("pipeline accepted a beat while the result was stalled");

endmodule

FILE: tb/div_result_checker.sv
// Scoreboard for the signed divider: predicts each accepted division and checks the results.
module div_result_checker
   import snd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,   // dividend, divisor
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [DATA_BITS-1:0] rsp_tdata,   // quotient, remainder
   input  logic [FLAG_BITS-1:0] rsp_tuser,   // zero_divisor, overflowed
   output int                   mismatches,
   output int                   outstanding
);

   typedef struct packed {
      logic [WIDTH-1:0] quotient;
      logic [WIDTH-1:0] remainder;
      logic             zero_divisor;
      logic             overflowed;
   } quot_rem_type;

   localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

   quot_rem_type expected_quot_rem[$];
   int           fail_total = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Divide magnitudes unsigned, then apply signs; remainder follows the dividend.
   function automatic quot_rem_type predict_division(logic [WIDTH-1:0] dvd,
                                                     logic [WIDTH-1:0] dvs);
      quot_rem_type     res;
      logic [WIDTH-1:0] mag_dvd;
      logic [WIDTH-1:0] mag_dvs;
      logic [WIDTH-1:0] mag_quo;
      logic [WIDTH-1:0] mag_rem;
      res = '0;
      if (dvs == '0) begin
         res.zero_divisor = 1'b1;
         res.quotient     = '1;
         res.remainder    = dvd;
      end else begin
         // negating the most negative value leaves its unsigned magnitude
         mag_dvd = dvd[WIDTH-1] ? ~dvd + 1'b1 : dvd;
         mag_dvs = dvs[WIDTH-1] ? ~dvs + 1'b1 : dvs;
         mag_quo = mag_dvd / mag_dvs;
         mag_rem = mag_dvd % mag_dvs;
         res.quotient   = (dvd[WIDTH-1] ^ dvs[WIDTH-1]) ? ~mag_quo + 1'b1 : mag_quo;
         res.remainder  = dvd[WIDTH-1] ? ~mag_rem + 1'b1 : mag_rem;
         res.overflowed = (dvd == MOST_NEG) && (dvs == '1);
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic [WIDTH-1:0] want,
                              input logic [WIDTH-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      quot_rem_type want;
      if (!reset) begin
         // a result beat can never belong to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_quot_rem.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %h/%h", $time,
                        rsp_tdata, rsp_tuser);
               fail_total++;
            end else begin
               want = expected_quot_rem.pop_front();
               check_field("quotient", want.quotient, rsp_tdata[WIDTH-1:0]);
               check_field("remainder", want.remainder, rsp_tdata[2*WIDTH-1:WIDTH]);
               check_field("zero_divisor", WIDTH'(want.zero_divisor), WIDTH'(rsp_tuser[0]));
               check_field("overflowed", WIDTH'(want.overflowed), WIDTH'(rsp_tuser[1]));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_quot_rem.push_back(predict_division(req_tdata[WIDTH-1:0],
                                                         req_tdata[2*WIDTH-1:WIDTH]));
         end
      end
      outstanding <= expected_quot_rem.size();
      mismatches  <= fail_total;
   end

endmodule

FILE: tb/tb.sv
// Top of the divider testbench: clock, reset, request and response traffic, verdict.
module tb;
   import snd_pkg::*;

   localparam int               RANDOM_ITEMS = 1350;
   localparam int               QUIET_ITEMS  = 200;
   localparam int               DRAIN_CYCLES = 40;
   localparam int               CYCLE_LIMIT  = 400000;
   localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [WIDTH-1:0] ALL_ONES = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata;   // dividend, divisor
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [DATA_BITS-1:0] rsp_tdata;   // quotient, remainder
   logic [FLAG_BITS-1:0] rsp_tuser;   // zero_divisor, overflowed

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   int gap_pct     = 0;
   int stall_pct   = 20;
   bit quiet       = 1'b0;

   // directed operands: divide by zero, most negative by minus one, sign combinations
   logic [WIDTH-1:0] dir_dvd[23] = '{
      '0, MOST_NEG, MOST_POS, ALL_ONES, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS,
      MOST_NEG, MOST_POS, MOST_NEG, WIDTH'(7), WIDTH'(-7), WIDTH'(7), WIDTH'(-7),
      WIDTH'(-6), '0, WIDTH'(3), WIDTH'(-3), ALL_ONES, MOST_NEG, WIDTH'(1), MOST_POS};
   logic [WIDTH-1:0] dir_dvs[23] = '{
      '0, '0, '0, '0, ALL_ONES, WIDTH'(1), ALL_ONES, MOST_POS,
      MOST_NEG, MOST_NEG, MOST_POS, WIDTH'(2), WIDTH'(2), WIDTH'(-2), WIDTH'(-2),
      WIDTH'(3), WIDTH'(-5), WIDTH'(7), WIDTH'(7), MOST_NEG, WIDTH'(2), WIDTH'(1), WIDTH'(1)};

   signed_nonrestoring_divider_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   div_result_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // mix of full-width values, shortened magnitudes, tiny values and edge values
   function automatic logic [WIDTH-1:0] random_operand();
      logic [WIDTH-1:0] v;
      v = WIDTH'($urandom);
      case ($urandom_range(0, 5))
         2: v = v >> $urandom_range(1, WIDTH - 1);
         3: v = ~(v >> $urandom_range(1, WIDTH - 1)) + 1'b1;
         4: v = WIDTH'($urandom_range(0, 40)) - WIDTH'(20);
         5: begin
            case ($urandom_range(0, 4))
               0: v = '0;
               1: v = WIDTH'(1);
               2: v = ALL_ONES;
               3: v = MOST_NEG;
               default: v = MOST_POS;
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_division(input logic [WIDTH-1:0] dvd, input logic [WIDTH-1:0] dvs);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dvs, dvd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // response side back-pressure
   initial begin
      rsp_tready <= 1'b0;
      repeat (4) @(posedge clock);
      forever begin
         if ($urandom_range(0, 255) == 0)
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_dvd[i]) send_division(dir_dvd[i], dir_dvs[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0)
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         if (n == RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         // let the pipeline run dry once
         if (n == 600) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: send_division(MOST_NEG, ALL_ONES);
               1: send_division(random_operand(), '0);
               default: send_division(random_operand(), ALL_ONES);
            endcase
         end else begin
            send_division(random_operand(), random_operand());
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
